@@ src/rird_pkg.sv @@
`timescale 1ns / 1ps
package rird_pkg;

    localparam int REPORT_MAX       = 23;
    localparam int READ_PAYLOAD_MAX = 16;
    localparam int NUM_CTRL         = 45;
    localparam int CNT_W            = $clog2(REPORT_MAX + 2);
    localparam int IDX_W            = $clog2(REPORT_MAX);
    localparam int RD_CNT_W         = $clog2(READ_PAYLOAD_MAX + 1);
    localparam int RD_IDX_W         = $clog2(READ_PAYLOAD_MAX);
    localparam int CTRL_ID_W        = $clog2(NUM_CTRL);

    localparam logic [7:0] REPORT_HEADER = 8'ha1;

    localparam logic [7:0] RID_STATUS   = 8'h20;
    localparam logic [7:0] RID_READ     = 8'h21;
    localparam logic [7:0] RID_ACK      = 8'h22;
    localparam logic [7:0] RID_CORE     = 8'h30;
    localparam logic [7:0] RID_CA       = 8'h31;
    localparam logic [7:0] RID_CE8      = 8'h32;
    localparam logic [7:0] RID_CA_IR    = 8'h33;
    localparam logic [7:0] RID_CE19     = 8'h34;
    localparam logic [7:0] RID_CAE      = 8'h35;
    localparam logic [7:0] RID_CIE      = 8'h36;
    localparam logic [7:0] RID_CAIE     = 8'h37;
    localparam logic [7:0] RID_EXT      = 8'h3d;
    localparam logic [7:0] RID_INTL_A   = 8'h3e;
    localparam logic [7:0] RID_INTL_B   = 8'h3f;

    localparam logic [1:0] EXT_NUNCHUK = 2'd1;
    localparam logic [1:0] EXT_CLASSIC = 2'd2;

    localparam logic [1:0] KIND_CTRL = 2'd0;
    localparam logic [1:0] KIND_READ = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    typedef struct packed {
        logic capture;
        logic finish;
        logic decode;
        logic load;
    } rird_cmd_t;

    typedef struct packed {
        logic have_event;
        logic out_free;
    } rird_sts_t;

    function automatic logic [CNT_W-1:0] min_len(input logic [7:0] id);
        logic [CNT_W-1:0] m;
        case (id) inside
            RID_STATUS, RID_READ: m = CNT_W'(8);
            RID_ACK:              m = CNT_W'(6);
            RID_CORE:             m = CNT_W'(4);
            RID_CA:               m = CNT_W'(7);
            RID_CE8:              m = CNT_W'(12);
            RID_CA_IR:            m = CNT_W'(19);
            RID_CE19, RID_CAE, RID_CIE, RID_CAIE, RID_EXT, RID_INTL_A, RID_INTL_B:
                                  m = CNT_W'(REPORT_MAX);
            default:              m = '1;
        endcase
        return m;
    endfunction

endpackage

@@ src/rird_ctrl.sv @@
`timescale 1ns / 1ps
module rird_ctrl
    import rird_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tlast,
    output logic       s_tready,
    input  rird_sts_t  sts,
    output rird_cmd_t  cmd
);

    localparam logic [1:0] ST_RECV   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_RECV;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_RECV: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                cmd.finish  = s_tvalid && s_tlast;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                cmd.decode = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!sts.have_event) begin
                    state_next = ST_RECV;
                end else begin
                    cmd.load = sts.out_free;
                end
            end
            default: state_next = ST_RECV;
        endcase
    end

endmodule

@@ src/rird_dp.sv @@
`timescale 1ns / 1ps
module rird_dp
    import rird_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,
    input  logic [7:0]  s_tdata,
    input  rird_cmd_t   cmd,
    output rird_sts_t   sts,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic [7:0] buf_reg  [REPORT_MAX];
    logic [7:0] prev_reg [REPORT_MAX];
    logic [CNT_W-1:0] cnt_reg, len_reg, prev_len_reg;
    logic diff_reg;
    logic [1:0] ext_reg;

    logic [7:0]  intl_reg [3];
    logic [15:0] core_reg;
    logic [7:0]  stat_reg, bat_reg;
    logic signed [9:0] acc_reg [3];
    logic signed [9:0] nun_reg [5];
    logic [1:0]  nkey_reg;
    logic signed [6:0] cls_reg [6];
    logic [15:0] ckey_reg;

    logic [NUM_CTRL-1:0] fire_reg, fire_next;
    logic [RD_CNT_W-1:0] rd_left_reg, rd_len_reg;
    logic [RD_IDX_W-1:0] rd_idx_reg;
    logic [15:0] rd_addr_reg;
    logic [3:0]  rd_err_reg;
    logic        ack_reg;
    logic [7:0]  ack_val_reg, ack_rid_reg;

    logic        out_valid_reg;
    logic [1:0]  o_kind_reg;
    logic [CTRL_ID_W-1:0] o_id_reg;
    logic [9:0]  o_val_reg;
    logic [15:0] o_addr_reg;
    logic [3:0]  o_err_reg;
    logic [RD_IDX_W-1:0] o_idx_reg;
    logic [RD_CNT_W-1:0] o_len_reg;
    logic [7:0]  o_ack_reg;
    logic        o_last_reg;

    // byte capture
    logic cnt_in_buf, byte_diff;
    logic [CNT_W-1:0] cnt_inc;

    assign cnt_in_buf = cnt_reg < CNT_W'(REPORT_MAX);
    assign byte_diff  = cnt_in_buf && (s_tdata != prev_reg[cnt_reg[IDX_W-1:0]]);
    assign cnt_inc    = (cnt_reg < CNT_W'(REPORT_MAX + 1)) ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (cmd.capture && cnt_in_buf) begin
            buf_reg[cnt_reg[IDX_W-1:0]] <= s_tdata;
        end
        if (cmd.capture && cmd.finish) begin
            len_reg <= cnt_inc;
        end
        if (cmd.capture) begin
            diff_reg <= ((cnt_reg == '0) ? 1'b0 : diff_reg) | byte_diff;
        end
    end

    // decode
    logic [7:0] rid;
    logic ok, go, core_en, stat_en, read_en, ack_en, acc_en, intl_en, ext_en, nun_en, cls_en;
    logic [15:0] core_new;
    logic [9:0]  acc_u [3];
    logic signed [9:0] acc_new [3];
    logic [7:0]  e [6];
    logic signed [9:0] nun_new [5];
    logic [1:0]  nkey_new;
    logic signed [6:0] cls_new [6];
    logic [15:0] ckey_new;
    logic [15:0] cdiff, kdiff;
    logic [NUM_CTRL-1:0] fire_dec;
    logic [7:0] x8, y8, z8;

    assign rid = buf_reg[1];

    always_comb begin
        ok = (len_reg >= CNT_W'(2)) && (len_reg <= CNT_W'(REPORT_MAX))
            && (buf_reg[0] == REPORT_HEADER)
            && !((len_reg == prev_len_reg) && !diff_reg);
        go = ok && (len_reg >= min_len(rid));
        core_en = go && (rid != RID_EXT);
        stat_en = go && (rid == RID_STATUS);
        read_en = go && (rid == RID_READ);
        ack_en  = go && (rid == RID_ACK);
        intl_en = go && (rid == RID_INTL_A);
        acc_en  = go && (rid == RID_CA || rid == RID_CA_IR || rid == RID_CAE
            || rid == RID_CAIE || rid == RID_INTL_B);
        ext_en  = go && (rid == RID_CE8 || rid == RID_CE19 || rid == RID_CAE
            || rid == RID_CIE || rid == RID_CAIE || rid == RID_EXT);
        nun_en  = ext_en && (ext_reg == EXT_NUNCHUK);
        cls_en  = ext_en && (ext_reg == EXT_CLASSIC);

        core_new = {buf_reg[2], buf_reg[3]};

        if (rid == RID_INTL_B) begin
            x8 = intl_reg[2];
            y8 = buf_reg[4];
            z8 = {intl_reg[1][6:5], intl_reg[0][6:5], buf_reg[3][6:5], buf_reg[2][6:5]};
            acc_u[0] = {x8, {2{x8[0]}}};
            acc_u[1] = {y8, {2{y8[0]}}};
            acc_u[2] = {z8, {2{z8[0]}}};
        end else begin
            x8 = buf_reg[4];
            y8 = buf_reg[5];
            z8 = buf_reg[6];
            acc_u[0] = {x8, buf_reg[2][6:5]};
            acc_u[1] = {y8, {2{buf_reg[3][5]}}};
            acc_u[2] = {z8, {2{buf_reg[3][6]}}};
        end
        for (int i = 0; i < 3; i++) begin
            acc_new[i] = {~acc_u[i][9], acc_u[i][8:0]};
        end

        for (int k = 0; k < 6; k++) begin
            case (rid)
                RID_CAE:  e[k] = buf_reg[7 + k];
                RID_CIE:  e[k] = buf_reg[14 + k];
                RID_CAIE: e[k] = buf_reg[17 + k];
                RID_EXT:  e[k] = buf_reg[2 + k];
                default:  e[k] = buf_reg[4 + k];
            endcase
        end

        nun_new[0] = $signed({2'b00, e[0]}) - 10'sd128;
        nun_new[1] = 10'sd128 - $signed({2'b00, e[1]});
        nun_new[2] = {~e[2][7], e[2][6:0], e[5][3:2]};
        nun_new[3] = {~e[3][7], e[3][6:0], e[5][5:4]};
        nun_new[4] = {~e[4][7], e[4][6:0], e[5][7:6]};
        nkey_new   = ~e[5][1:0];

        cls_new[0] = $signed({1'b0, e[0][5:0]}) - 7'sd32;
        cls_new[1] = 7'sd32 - $signed({1'b0, e[1][5:0]});
        cls_new[2] = $signed({2'b00, e[0][7:6], e[1][7:6], e[2][7]}) - 7'sd16;
        cls_new[3] = 7'sd16 - $signed({2'b00, e[2][4:0]});
        cls_new[4] = {2'b00, e[2][6:5], e[3][7:5]};
        cls_new[5] = {2'b00, e[3][4:0]};
        ckey_new   = ~{e[4], e[5]};

        cdiff = core_reg ^ core_new;
        kdiff = ckey_reg ^ ckey_new;
        fire_dec = '0;
        if (core_en) begin
            fire_dec[4:0]  = cdiff[4:0];
            fire_dec[5]    = cdiff[7];
            fire_dec[10:6] = cdiff[12:8];
        end
        if (stat_en) begin
            fire_dec[11] = stat_reg[0] ^ buf_reg[4][0];
            fire_dec[12] = stat_reg[1] ^ buf_reg[4][1];
            fire_dec[13] = bat_reg != buf_reg[5];
        end
        if (acc_en) begin
            for (int i = 0; i < 3; i++) fire_dec[14 + i] = acc_reg[i] != acc_new[i];
        end
        if (nun_en) begin
            for (int i = 0; i < 5; i++) fire_dec[17 + i] = nun_reg[i] != nun_new[i];
            fire_dec[23:22] = nkey_reg ^ nkey_new;
        end
        if (cls_en) begin
            for (int i = 0; i < 6; i++) fire_dec[24 + i] = cls_reg[i] != cls_new[i];
            fire_dec[37:30] = kdiff[7:0];
            fire_dec[44:38] = kdiff[15:9];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < REPORT_MAX; k++) prev_reg[k] <= '0;
            prev_len_reg <= '0;
            cnt_reg      <= '0;
            ext_reg      <= '0;
            for (int k = 0; k < 3; k++) intl_reg[k] <= '0;
            core_reg <= '0;
            stat_reg <= '0;
            bat_reg  <= '0;
            for (int k = 0; k < 3; k++) acc_reg[k] <= '0;
            for (int k = 0; k < 5; k++) nun_reg[k] <= '0;
            nkey_reg <= '0;
            for (int k = 0; k < 6; k++) cls_reg[k] <= '0;
            ckey_reg <= '0;
        end else begin
            if (cfg_we) begin
                ext_reg <= cfg_wdata;
            end
            if (cmd.capture) begin
                cnt_reg <= cmd.finish ? '0 : cnt_inc;
            end
            if (cmd.decode) begin
                if (ok) begin
                    for (int k = 0; k < REPORT_MAX; k++) begin
                        if (CNT_W'(k) < len_reg) prev_reg[k] <= buf_reg[k];
                    end
                    prev_len_reg <= len_reg;
                end
                if (intl_en) begin
                    for (int k = 0; k < 3; k++) intl_reg[k] <= buf_reg[2 + k];
                end
                if (core_en) core_reg <= core_new;
                if (stat_en) begin
                    stat_reg <= buf_reg[4];
                    bat_reg  <= buf_reg[5];
                end
                if (acc_en) begin
                    for (int k = 0; k < 3; k++) acc_reg[k] <= acc_new[k];
                end
                if (nun_en) begin
                    for (int k = 0; k < 5; k++) nun_reg[k] <= nun_new[k];
                    nkey_reg <= nkey_new;
                end
                if (cls_en) begin
                    for (int k = 0; k < 6; k++) cls_reg[k] <= cls_new[k];
                    ckey_reg <= ckey_new;
                end
            end
        end
    end

    // event selection
    logic [CTRL_ID_W-1:0] sel_id;
    logic [NUM_CTRL-1:0]  fire_rest;
    logic signed [9:0]    ctrl_val;
    logic [CNT_W-1:0]     rd_pos;
    logic [7:0]           rd_byte;
    logic                 ev_last;

    always_comb begin
        sel_id = '0;
        for (int i = NUM_CTRL - 1; i >= 0; i--) begin
            if (fire_reg[i]) sel_id = CTRL_ID_W'(i);
        end
        fire_rest = fire_reg & (fire_reg - 1'b1);

        if (sel_id <= CTRL_ID_W'(4)) begin
            ctrl_val = {9'd0, core_reg[sel_id[3:0]]};
        end else if (sel_id == CTRL_ID_W'(5)) begin
            ctrl_val = {9'd0, core_reg[7]};
        end else if (sel_id <= CTRL_ID_W'(10)) begin
            ctrl_val = {9'd0, core_reg[4'(sel_id + CTRL_ID_W'(2))]};
        end else if (sel_id <= CTRL_ID_W'(12)) begin
            ctrl_val = {9'd0, stat_reg[sel_id[0] ? 0 : 1]};
        end else if (sel_id == CTRL_ID_W'(13)) begin
            ctrl_val = {2'b00, bat_reg};
        end else if (sel_id <= CTRL_ID_W'(16)) begin
            ctrl_val = acc_reg[2'(sel_id - CTRL_ID_W'(14))];
        end else if (sel_id <= CTRL_ID_W'(21)) begin
            ctrl_val = nun_reg[3'(sel_id - CTRL_ID_W'(17))];
        end else if (sel_id <= CTRL_ID_W'(23)) begin
            ctrl_val = {9'd0, nkey_reg[sel_id[0]]};
        end else if (sel_id <= CTRL_ID_W'(29)) begin
            ctrl_val = 10'(cls_reg[3'(sel_id - CTRL_ID_W'(24))]);
        end else if (sel_id <= CTRL_ID_W'(37)) begin
            ctrl_val = {9'd0, ckey_reg[4'(sel_id - CTRL_ID_W'(30))]};
        end else begin
            ctrl_val = {9'd0, ckey_reg[4'(sel_id - CTRL_ID_W'(29))]};
        end

        rd_pos  = CNT_W'(7) + CNT_W'(rd_idx_reg);
        rd_byte = (rd_pos < len_reg) ? buf_reg[rd_pos[IDX_W-1:0]] : 8'd0;

        if (fire_reg != '0) begin
            ev_last = (fire_rest == '0) && (rd_left_reg == '0) && !ack_reg;
        end else if (rd_left_reg != '0) begin
            ev_last = (rd_left_reg == RD_CNT_W'(1)) && !ack_reg;
        end else begin
            ev_last = 1'b1;
        end

        fire_next = fire_reg;
        if (cmd.decode) begin
            fire_next = fire_dec;
        end else if (cmd.load && fire_reg != '0) begin
            fire_next = fire_rest;
        end
    end

    assign sts.have_event = (fire_reg != '0) || (rd_left_reg != '0) || ack_reg;
    assign sts.out_free   = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fire_reg      <= '0;
            rd_left_reg   <= '0;
            rd_idx_reg    <= '0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fire_reg <= fire_next;
            if (cmd.decode) begin
                rd_left_reg <= read_en ? RD_CNT_W'(buf_reg[4][7:4]) + 1'b1 : '0;
                rd_idx_reg  <= '0;
                ack_reg     <= ack_en;
            end else if (cmd.load && fire_reg == '0) begin
                if (rd_left_reg != '0) begin
                    rd_left_reg <= rd_left_reg - 1'b1;
                    rd_idx_reg  <= rd_idx_reg + 1'b1;
                end else begin
                    ack_reg <= 1'b0;
                end
            end
            if (cmd.load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.decode) begin
            rd_len_reg  <= RD_CNT_W'(buf_reg[4][7:4]) + 1'b1;
            rd_err_reg  <= buf_reg[4][3:0];
            rd_addr_reg <= {buf_reg[5], buf_reg[6]};
            ack_val_reg <= buf_reg[5];
            ack_rid_reg <= buf_reg[4];
        end
        if (cmd.load) begin
            o_last_reg <= ev_last;
            o_id_reg   <= '0;
            o_addr_reg <= '0;
            o_err_reg  <= '0;
            o_idx_reg  <= '0;
            o_len_reg  <= '0;
            o_ack_reg  <= '0;
            if (fire_reg != '0) begin
                o_kind_reg <= KIND_CTRL;
                o_id_reg   <= sel_id;
                o_val_reg  <= ctrl_val;
            end else if (rd_left_reg != '0) begin
                o_kind_reg <= KIND_READ;
                o_val_reg  <= {2'b00, rd_byte};
                o_addr_reg <= rd_addr_reg;
                o_err_reg  <= rd_err_reg;
                o_idx_reg  <= rd_idx_reg;
                o_len_reg  <= rd_len_reg;
            end else begin
                o_kind_reg <= KIND_ACK;
                o_val_reg  <= {2'b00, ack_val_reg};
                o_ack_reg  <= ack_rid_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = o_kind_reg;
    assign m_tlast  = o_last_reg;
    assign m_tdata  = {3'b000, o_ack_reg, o_len_reg, o_idx_reg, o_err_reg, o_addr_reg,
                       o_val_reg, o_id_reg};

endmodule

@@ src/remote_input_report_decoder.sv @@
// Sequence: a report's last byte moves the controller to a decode state, then to an emit
// state that loads results into the single output register, one result per cycle while
// it is free (not valid, or m_tready high). Throughput: one report byte per cycle while
// receiving; s_tready stays low from a report's last byte until its N results (up to 35) are loaded.
// Reset (aresetn low, synchronous) clears all kept values, previous report and counters.
`timescale 1ns / 1ps
module remote_input_report_decoder
    import rird_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata,     // ext_type
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // data_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,       // control_id, value, mem_addr, mem_error,
                                       // read_index, read_length, ack_report
    output logic [1:0]  m_tuser,       // event_kind
    output logic        m_tlast
);

    rird_cmd_t cmd;
    rird_sts_t sts;

    rird_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    rird_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule
